>>> rtl/slic_pkg.sv
package slic_pkg;

   localparam int CAPACITY   = 64;
   localparam int VALUE_W    = 32;
   localparam int FIELD_W    = 7;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int GROUP      = 8;
   localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;
   localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int GSUM_W     = $clog2(GROUP + 1);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_COUNT  = 1'b1;

   typedef struct packed {
      logic                      valid;
      logic                      gt;
      logic signed [VALUE_W-1:0] value;
   } cell_link_type;

endpackage

>>> rtl/slic_cell.sv
module slic_cell
   import slic_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      insert_en,
   input  logic                      cmp_en,
   input  logic signed [VALUE_W-1:0] item_value,
   input  cell_link_type             prev_link,
   output cell_link_type             this_link,
   output logic                      eq_ff
);

   logic                      valid_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic                      gt;

   // An empty cell counts as greater than any item, so the insert point is the first
   // cell that is empty or holds a larger value.
   assign gt = !valid_ff || (item_value < value_ff);

   assign this_link.valid = valid_ff;
   assign this_link.gt    = gt;
   assign this_link.value = value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (insert_en && gt) begin
         valid_ff <= valid_ff | prev_link.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (insert_en && gt) begin
         value_ff <= prev_link.gt ? prev_link.value : item_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_en) begin
         eq_ff <= valid_ff && (item_value == value_ff);
      end
   end

endmodule

>>> rtl/sorted_list_insert_and_count.sv
// Keeps up to CAPACITY signed 32-bit values in ascending order in a row of cells, each
// holding one entry and shifting it to its neighbour when an insert lands below it; an
// equal value goes after those already stored. The result beat of an insert is offered in
// the cycle after the insert beat is accepted. A count beat compares every cell at once,
// then tallies the match flags eight cells per cycle, and no further beat is accepted
// until the result beat has been taken. Each result carries the number of stored entries;
// an insert into a full list is dropped and flagged. Only the low seven bits of the counts
// are reported.
module sorted_list_insert_and_count
   import slic_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_op,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [FIELD_W-1:0]        rsp_match_count,
   output logic [FIELD_W-1:0]        rsp_total_entries,
   output logic                      rsp_full_drop
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_RESP
   } state_type;

   state_type                  state_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           acc_ff;
   logic [GRP_W-1:0]           grp_ff;
   logic [FIELD_W-1:0]         match_ff;
   logic [FIELD_W-1:0]         total_ff;
   logic                       drop_ff;

   logic                       accept;
   logic                       full;
   logic                       insert_en;
   logic                       cmp_en;
   cell_link_type              links [CAPACITY+1];
   logic [CAPACITY-1:0]        eq_vec;
   logic [NUM_GROUPS*GROUP-1:0] eq_pad;
   logic [GROUP-1:0]           grp_bits;
   logic [GSUM_W-1:0]          grp_sum;
   logic [CNT_W-1:0]           acc_in;
   logic                       last_grp;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign insert_en = accept && (req_op == OP_INSERT) && !full;
   assign cmp_en    = accept && (req_op == OP_COUNT);

   assign links[0].valid = 1'b1;
   assign links[0].gt    = 1'b0;
   assign links[0].value = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      slic_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .insert_en  (insert_en),
         .cmp_en     (cmp_en),
         .item_value (req_value),
         .prev_link  (links[i]),
         .this_link  (links[i+1]),
         .eq_ff      (eq_vec[i])
      );
   end

   assign eq_pad   = (NUM_GROUPS*GROUP)'(eq_vec);
   assign grp_bits = eq_pad[grp_ff*GROUP +: GROUP];

   always_comb begin
      grp_sum = '0;
      for (int k = 0; k < GROUP; k++) begin
         grp_sum = grp_sum + GSUM_W'(grp_bits[k]);
      end
   end

   assign acc_in   = acc_ff + CNT_W'(grp_sum);
   assign last_grp = (grp_ff == GRP_W'(NUM_GROUPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  acc_ff <= '0;
                  grp_ff <= '0;
                  if (req_op == OP_COUNT) begin
                     state_ff <= ST_SUM;
                  end else begin
                     state_ff <= ST_RESP;
                     match_ff <= '0;
                     drop_ff  <= full;
                     if (full) begin
                        total_ff <= FIELD_W'(count_ff);
                     end else begin
                        count_ff <= count_ff + 1'b1;
                        total_ff <= FIELD_W'(count_ff + 1'b1);
                     end
                  end
               end
            end
            ST_SUM: begin
               acc_ff <= acc_in;
               grp_ff <= grp_ff + 1'b1;
               if (last_grp) begin
                  state_ff <= ST_RESP;
                  match_ff <= FIELD_W'(acc_in);
                  total_ff <= FIELD_W'(count_ff);
                  drop_ff  <= 1'b0;
               end
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = (state_ff == ST_RESP);
   assign rsp_match_count   = match_ff;
   assign rsp_total_entries = total_ff;
   assign rsp_full_drop     = drop_ff;

endmodule
